FILE: design/ndtp_pkg.sv
// Shared types and constants of the NDEF text record parser.
`timescale 1ns / 1ps
`default_nettype none

package ndtp_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TNF_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PAYLEN_W  = 32;
  localparam int unsigned LENCNT_W  = 2;
  localparam int unsigned LANG_W    = 6;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TNF  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TYPE = 8'd1;

  // Configuration reset values
  localparam logic [TNF_W-1:0]  TNF_RESET  = 3'd1;
  localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h54;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DATA  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TLV_ERR  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NDEF_ERR = 2'd3;

  // Tag format constants
  localparam logic [BYTE_W-1:0] CC_MAGIC     = 8'hE1;
  localparam logic [BYTE_W-1:0] VER_MASK     = 8'hF0;
  localparam logic [BYTE_W-1:0] VER_MAJOR    = 8'h40;
  localparam logic [BYTE_W-1:0] TLV_NDEF     = 8'h03;
  localparam logic [BYTE_W-1:0] CC_SKIP      = 8'd2;
  localparam logic [BYTE_W-1:0] ONE_TYPE_LEN = 8'd1;
  localparam int unsigned       HDR_SR_BIT   = 4;
  localparam int unsigned       HDR_IL_BIT   = 3;
  localparam logic [LENCNT_W-1:0] LEN_LAST   = 2'd3;

  // Parse phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE      = 15'b000000000000001,
    PH_VERSION   = 15'b000000000000010,
    PH_SKIP_CC   = 15'b000000000000100,
    PH_CONTENT   = 15'b000000000001000,
    PH_SKIP_LEN  = 15'b000000000010000,
    PH_HEADER    = 15'b000000000100000,
    PH_TYPE_LEN  = 15'b000000001000000,
    PH_PAY_LEN   = 15'b000000010000000,
    PH_ID_LEN    = 15'b000000100000000,
    PH_TYPE      = 15'b000001000000000,
    PH_SKIP_ID   = 15'b000010000000000,
    PH_LANG      = 15'b000100000000000,
    PH_SKIP_LANG = 15'b001000000000000,
    PH_TEXT      = 15'b010000000000000,
    PH_DONE      = 15'b100000000000000
  } phase_t;

  // One tag byte with its markers
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } item_t;

  // One parser result
  typedef struct packed {
    logic [BYTE_W-1:0]   text_byte;
    logic                text_valid;
    logic                last;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Accepted record format
  typedef struct packed {
    logic [TNF_W-1:0]  tnf;
    logic [BYTE_W-1:0] rec_type;
  } match_cfg_t;

endpackage

`default_nettype wire

FILE: design/ndtp_cfg_regs.sv
// Configuration registers: accepted TNF and record type.
`timescale 1ns / 1ps
`default_nettype none

module ndtp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [ndtp_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [ndtp_pkg::BYTE_W-1:0]    wr_data,
  output ndtp_pkg::match_cfg_t                match_cfg
);

  logic [ndtp_pkg::TNF_W-1:0]  tnf_r, tnf_nxt;
  logic [ndtp_pkg::BYTE_W-1:0] type_r, type_nxt;

  // Decode the register index; other indexes are dropped
  always_comb begin
    tnf_nxt  = tnf_r;
    type_nxt = type_r;
    if (wr_en) begin
      if (wr_index == ndtp_pkg::CFG_IDX_TNF) begin
        tnf_nxt = wr_data[ndtp_pkg::TNF_W-1:0];
      end
      if (wr_index == ndtp_pkg::CFG_IDX_TYPE) begin
        type_nxt = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tnf_r  <= ndtp_pkg::TNF_RESET;
      type_r <= ndtp_pkg::TYPE_RESET;
    end else begin
      tnf_r  <= tnf_nxt;
      type_r <= type_nxt;
    end
  end

  assign match_cfg.tnf      = tnf_r;
  assign match_cfg.rec_type = type_r;

endmodule

`default_nettype wire

FILE: design/ndtp_in_stage.sv
// Input register: holds one accepted tag byte until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module ndtp_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ndtp_pkg::item_t in_item,
  input  wire logic            take,
  output logic                 hold_valid,
  output ndtp_pkg::item_t      hold_item
);

  logic            valid_r, valid_nxt;
  ndtp_pkg::item_t item_r, item_nxt;

  // Free when empty or emptied in this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

`default_nettype wire

FILE: design/ndtp_parse_fsm.sv
// Parse state machine: advances one tag byte per step and forms its result.
`timescale 1ns / 1ps
`default_nettype none

module ndtp_parse_fsm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire ndtp_pkg::item_t      item,
  input  wire ndtp_pkg::match_cfg_t match_cfg,
  output logic                      has_result,
  output ndtp_pkg::result_t         result
);

  ndtp_pkg::phase_t                 phase_r, phase_nxt;
  logic [ndtp_pkg::BYTE_W-1:0]      skip_r, skip_nxt;
  logic [ndtp_pkg::PAYLEN_W-1:0]    pay_r, pay_nxt;
  logic [ndtp_pkg::LENCNT_W-1:0]    lencnt_r, lencnt_nxt;
  logic                             short_r, short_nxt;
  logic                             has_id_r, has_id_nxt;
  logic [ndtp_pkg::BYTE_W-1:0]      type_len_r, type_len_nxt;
  logic [ndtp_pkg::BYTE_W-1:0]      id_len_r, id_len_nxt;

  // Next state and result of the byte at hand
  always_comb begin
    logic [ndtp_pkg::BYTE_W-1:0]   b;
    logic                          restart;
    logic [ndtp_pkg::LANG_W-1:0]   lang;
    logic [ndtp_pkg::PAYLEN_W:0]   lang_diff;
    logic                          res_text;
    logic                          res_end;
    logic                          res_err;
    logic [ndtp_pkg::STATUS_W-1:0] code;

    b          = item.data_byte;
    restart    = item.first_byte;
    lang       = b[ndtp_pkg::LANG_W-1:0];
    res_text   = 1'b0;
    res_end    = 1'b0;
    res_err    = 1'b0;
    code       = ndtp_pkg::ST_OK;

    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    pay_nxt      = pay_r;
    lencnt_nxt   = lencnt_r;
    short_nxt    = short_r;
    has_id_nxt   = has_id_r;
    type_len_nxt = type_len_r;
    id_len_nxt   = id_len_r;

    // Restart the message on its first byte
    if (restart) begin
      skip_nxt     = '0;
      pay_nxt      = '0;
      lencnt_nxt   = '0;
      short_nxt    = 1'b0;
      has_id_nxt   = 1'b0;
      type_len_nxt = '0;
      id_len_nxt   = '0;
      phase_nxt    = (b == ndtp_pkg::CC_MAGIC) ? ndtp_pkg::PH_VERSION
                                               : ndtp_pkg::PH_HEADER;
    end

    lang_diff = {1'b0, pay_nxt} - {{(ndtp_pkg::PAYLEN_W + 1 - ndtp_pkg::LANG_W){1'b0}}, lang}
                - {{ndtp_pkg::PAYLEN_W{1'b0}}, 1'b1};

    // The capability container magic is consumed by the restart alone
    if (!(restart && b == ndtp_pkg::CC_MAGIC)) begin
      unique case (phase_nxt)
        ndtp_pkg::PH_VERSION: begin
          if ((b & ndtp_pkg::VER_MASK) != ndtp_pkg::VER_MAJOR) begin
            res_err = 1'b1;
            code    = ndtp_pkg::ST_TLV_ERR;
          end else begin
            skip_nxt  = ndtp_pkg::CC_SKIP;
            phase_nxt = ndtp_pkg::PH_SKIP_CC;
          end
        end
        ndtp_pkg::PH_SKIP_CC: begin
          skip_nxt = skip_nxt - 8'd1;
          if (skip_nxt == '0) phase_nxt = ndtp_pkg::PH_CONTENT;
        end
        ndtp_pkg::PH_CONTENT: begin
          if (b != ndtp_pkg::TLV_NDEF) begin
            res_err = 1'b1;
            code    = ndtp_pkg::ST_NO_DATA;
          end else begin
            phase_nxt = ndtp_pkg::PH_SKIP_LEN;
          end
        end
        ndtp_pkg::PH_SKIP_LEN: begin
          phase_nxt = ndtp_pkg::PH_HEADER;
        end
        ndtp_pkg::PH_HEADER: begin
          short_nxt  = b[ndtp_pkg::HDR_SR_BIT];
          has_id_nxt = b[ndtp_pkg::HDR_IL_BIT];
          if (b[ndtp_pkg::TNF_W-1:0] != match_cfg.tnf) begin
            res_err = 1'b1;
            code    = ndtp_pkg::ST_NDEF_ERR;
          end else begin
            phase_nxt = ndtp_pkg::PH_TYPE_LEN;
          end
        end
        ndtp_pkg::PH_TYPE_LEN: begin
          type_len_nxt = b;
          pay_nxt      = '0;
          lencnt_nxt   = '0;
          phase_nxt    = ndtp_pkg::PH_PAY_LEN;
        end
        ndtp_pkg::PH_PAY_LEN: begin
          pay_nxt = {pay_nxt[ndtp_pkg::PAYLEN_W-ndtp_pkg::BYTE_W-1:0], b};
          if (short_nxt || lencnt_nxt == ndtp_pkg::LEN_LAST) begin
            if (has_id_nxt) begin
              phase_nxt = ndtp_pkg::PH_ID_LEN;
            end else if (type_len_nxt != ndtp_pkg::ONE_TYPE_LEN) begin
              res_err = 1'b1;
              code    = ndtp_pkg::ST_NDEF_ERR;
            end else begin
              phase_nxt = ndtp_pkg::PH_TYPE;
            end
          end else begin
            lencnt_nxt = lencnt_nxt + 2'd1;
          end
        end
        ndtp_pkg::PH_ID_LEN: begin
          id_len_nxt = b;
          if (type_len_nxt != ndtp_pkg::ONE_TYPE_LEN) begin
            res_err = 1'b1;
            code    = ndtp_pkg::ST_NDEF_ERR;
          end else begin
            phase_nxt = ndtp_pkg::PH_TYPE;
          end
        end
        ndtp_pkg::PH_TYPE: begin
          if (b != match_cfg.rec_type) begin
            res_err = 1'b1;
            code    = ndtp_pkg::ST_NDEF_ERR;
          end else if (id_len_nxt != '0) begin
            skip_nxt  = id_len_nxt;
            phase_nxt = ndtp_pkg::PH_SKIP_ID;
          end else begin
            phase_nxt = ndtp_pkg::PH_LANG;
          end
        end
        ndtp_pkg::PH_SKIP_ID: begin
          skip_nxt = skip_nxt - 8'd1;
          if (skip_nxt == '0) phase_nxt = ndtp_pkg::PH_LANG;
        end
        ndtp_pkg::PH_LANG: begin
          // Status byte: flag a payload too short for the language code
          if (lang_diff[ndtp_pkg::PAYLEN_W]) begin
            res_err = 1'b1;
            code    = ndtp_pkg::ST_NDEF_ERR;
          end else begin
            pay_nxt = lang_diff[ndtp_pkg::PAYLEN_W-1:0];
            if (lang != '0) begin
              skip_nxt  = {{(ndtp_pkg::BYTE_W - ndtp_pkg::LANG_W){1'b0}}, lang};
              phase_nxt = ndtp_pkg::PH_SKIP_LANG;
            end else if (pay_nxt == '0) begin
              phase_nxt = ndtp_pkg::PH_DONE;
              res_end   = 1'b1;
            end else begin
              phase_nxt = ndtp_pkg::PH_TEXT;
            end
          end
        end
        ndtp_pkg::PH_SKIP_LANG: begin
          skip_nxt = skip_nxt - 8'd1;
          if (skip_nxt == '0) begin
            if (pay_nxt == '0) begin
              phase_nxt = ndtp_pkg::PH_DONE;
              res_end   = 1'b1;
            end else begin
              phase_nxt = ndtp_pkg::PH_TEXT;
            end
          end
        end
        ndtp_pkg::PH_TEXT: begin
          // Drop a text byte that the tag cuts short
          if (pay_nxt == 32'd1 || !item.last_byte) begin
            pay_nxt  = pay_nxt - 32'd1;
            res_text = 1'b1;
            if (pay_nxt == '0) phase_nxt = ndtp_pkg::PH_DONE;
          end
        end
        ndtp_pkg::PH_IDLE: begin
          phase_nxt = ndtp_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = ndtp_pkg::PH_DONE;
        end
      endcase
    end

    // Tag ran out before the message finished
    if (!res_text && !res_end && !res_err && item.last_byte &&
        phase_nxt != ndtp_pkg::PH_DONE && phase_nxt != ndtp_pkg::PH_IDLE) begin
      res_err = 1'b1;
      code    = ndtp_pkg::ST_NO_DATA;
    end
    if (res_err) phase_nxt = ndtp_pkg::PH_DONE;

    has_result        = res_text || res_end || res_err;
    result.text_byte  = res_text ? b : '0;
    result.text_valid = res_text;
    result.last       = res_text ? (pay_nxt == '0) : 1'b1;
    result.status     = res_err ? code : ndtp_pkg::ST_OK;
  end

  // Commit the state only when the byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= ndtp_pkg::PH_IDLE;
      skip_r     <= '0;
      pay_r      <= '0;
      lencnt_r   <= '0;
      short_r    <= 1'b0;
      has_id_r   <= 1'b0;
      type_len_r <= '0;
      id_len_r   <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      pay_r      <= pay_nxt;
      lencnt_r   <= lencnt_nxt;
      short_r    <= short_nxt;
      has_id_r   <= has_id_nxt;
      type_len_r <= type_len_nxt;
      id_len_r   <= id_len_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/ndtp_out_stage.sv
// Output register: holds one result until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module ndtp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire ndtp_pkg::result_t load_result,
  output logic                   can_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ndtp_pkg::result_t      out_result
);

  logic              valid_r, valid_nxt;
  ndtp_pkg::result_t result_r, result_nxt;

  // Room when empty or drained in this cycle
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt  = valid_r;
    result_nxt = result_r;
    if (load) begin
      valid_nxt  = 1'b1;
      result_nxt = load_result;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

FILE: design/ndef_text_record_parser_unit.sv
// Top level of the NDEF text record parser.
//
// Tag memory enters one byte per item on the in_ channel (valid/ready),
// with first_byte marking the start of tag memory and last_byte the final
// byte available. Each item yields zero or one result on the out_ channel:
// a text character, an empty-text end marker, or a status result with last.
// Two registers on the cfg_ channel select the accepted TNF (index 0) and
// record type (index 1); cfg_ready is always high.
//
// Throughput: one item per cycle unless the receiver stalls. An accepted
// item is held in the input register, where the phase machine processes it;
// when the output register has room the item is taken and its result, if
// any, is loaded into the output register, which drives out_valid.
// When the receiver stalls, the output register holds its result and the
// input register holds one more item; in_ready falls only while both are
// full. Items that give no result still wait for room in the output register.
// Reset (rst_n low, synchronous) empties both registers, puts the parser
// in its idle phase and restores TNF 1 and type 'T'.
`timescale 1ns / 1ps
`default_nettype none

module ndef_text_record_parser_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ndtp_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                           in_first_byte,
  input  wire logic                           in_last_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ndtp_pkg::BYTE_W-1:0]         out_text_byte,
  output logic                                out_text_valid,
  output logic                                out_last,
  output logic [ndtp_pkg::STATUS_W-1:0]       out_status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ndtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ndtp_pkg::BYTE_W-1:0]    cfg_data
);

  ndtp_pkg::item_t      in_item;
  ndtp_pkg::item_t      hold_item;
  ndtp_pkg::match_cfg_t match_cfg;
  ndtp_pkg::result_t    step_result;
  ndtp_pkg::result_t    out_result;
  logic                 hold_valid;
  logic                 can_take;
  logic                 take;
  logic                 has_result;

  assign cfg_ready = 1'b1;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.first_byte = in_first_byte;
  assign in_item.last_byte  = in_last_byte;

  // Advance the held byte when the output register has room
  assign take = hold_valid && can_take;

  ndtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .match_cfg (match_cfg)
  );

  ndtp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  ndtp_parse_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (take),
    .item       (hold_item),
    .match_cfg  (match_cfg),
    .has_result (has_result),
    .result     (step_result)
  );

  ndtp_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (take && has_result),
    .load_result (step_result),
    .can_take    (can_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign out_text_byte  = out_result.text_byte;
  assign out_text_valid = out_result.text_valid;
  assign out_last       = out_result.last;
  assign out_status     = out_result.status;

  // Input side backs up only while both registers are full and stalled
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("in_ready high with both stages full and stalled");

  // A result without a character always closes the message
  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_text_valid) |-> out_last)
    else $error("non-text result without last");

  // Text results carry no error status
  a_text_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_valid) |-> (out_status == ndtp_pkg::ST_OK))
    else $error("text result with error status");

  // A byte taken with room loads a result in the next cycle if it had one
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (take && has_result) |=> out_valid)
    else $error("result lost after step");

endmodule

`default_nettype wire

FILE: tb/tb_ndef_text_record_parser_unit.sv
// Self-checking testbench for the NDEF text record parser unit.
`timescale 1ns / 1ps

module tb_ndef_text_record_parser_unit;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned PHASE_QUOTA   = 280;
  localparam logic [ndtp_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

  typedef logic [ndtp_pkg::BYTE_W-1:0] byte_q_t[$];

  // Kind of outcome a tag byte produces
  typedef enum logic [1:0] {RK_NONE, RK_TEXT, RK_END, RK_ERR} res_kind_t;

  // Field values of one generated tag image
  typedef struct {
    logic                        cc;
    logic [ndtp_pkg::BYTE_W-1:0] ver;
    logic [ndtp_pkg::BYTE_W-1:0] tlv;
    logic [ndtp_pkg::BYTE_W-1:0] hdr;
    logic [ndtp_pkg::BYTE_W-1:0] tlen;
    logic [ndtp_pkg::BYTE_W-1:0] id_len;
    logic [ndtp_pkg::BYTE_W-1:0] rtype;
    logic [ndtp_pkg::BYTE_W-1:0] stat;
    logic [31:0]                 plen;
    int                          text_len;
  } tag_msg_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [ndtp_pkg::BYTE_W-1:0]    in_data_byte;
  logic                           in_first_byte;
  logic                           in_last_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic [ndtp_pkg::BYTE_W-1:0]    out_text_byte;
  logic                           out_text_valid;
  logic                           out_last;
  logic [ndtp_pkg::STATUS_W-1:0]  out_status;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ndtp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ndtp_pkg::BYTE_W-1:0]    cfg_data;

  // Parser state as the testbench predicts it
  ndtp_pkg::phase_t              parse_ph;
  logic [ndtp_pkg::BYTE_W-1:0]   skip_left;
  logic [ndtp_pkg::PAYLEN_W-1:0] pay_left;
  logic [ndtp_pkg::LENCNT_W-1:0] len_cnt;
  logic                          sr_flag;
  logic                          il_flag;
  logic [ndtp_pkg::BYTE_W-1:0]   type_len;
  logic [ndtp_pkg::BYTE_W-1:0]   id_len;
  logic [ndtp_pkg::TNF_W-1:0]    tnf_cfg;
  logic [ndtp_pkg::BYTE_W-1:0]   type_cfg;

  ndtp_pkg::result_t pending_results[$];
  int                mismatches = 0;
  int                bytes_sent = 0;

  // Format the stimulus builds well-formed records for
  logic [ndtp_pkg::TNF_W-1:0]  stim_tnf  = ndtp_pkg::TNF_RESET;
  logic [ndtp_pkg::BYTE_W-1:0] stim_type = ndtp_pkg::TYPE_RESET;

  bit tx_gap_en     = 1'b1;
  bit rx_stall_en   = 1'b1;
  bit long_hold_req = 1'b0;

  ndef_text_record_parser_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_first_byte  (in_first_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_byte  (out_text_byte),
    .out_text_valid (out_text_valid),
    .out_last       (out_last),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Finish the language code: either the record is done or text follows
  function automatic res_kind_t end_of_lang();
    if (pay_left == '0) begin
      parse_ph = ndtp_pkg::PH_DONE;
      return RK_END;
    end
    parse_ph = ndtp_pkg::PH_TEXT;
    return RK_NONE;
  endfunction

  // Advance the predicted parser by one tag byte and queue its result
  function automatic void parse_tag_byte(ndtp_pkg::item_t it);
    logic [ndtp_pkg::BYTE_W-1:0]   b;
    res_kind_t                     kind;
    logic [ndtp_pkg::STATUS_W-1:0] code;
    logic [ndtp_pkg::LANG_W-1:0]   lang;
    logic                          cc_start;
    ndtp_pkg::result_t             r;
    b        = it.data_byte;
    kind     = RK_NONE;
    code     = ndtp_pkg::ST_OK;
    cc_start = 1'b0;
    // restart on the first byte of tag memory
    if (it.first_byte) begin
      skip_left = '0;
      pay_left  = '0;
      len_cnt   = '0;
      sr_flag   = 1'b0;
      il_flag   = 1'b0;
      type_len  = '0;
      id_len    = '0;
      cc_start  = (b == ndtp_pkg::CC_MAGIC);
      parse_ph  = cc_start ? ndtp_pkg::PH_VERSION : ndtp_pkg::PH_HEADER;
      if (cc_start) b = '0;
    end
    if (!cc_start) begin
      case (parse_ph)
        ndtp_pkg::PH_VERSION: begin
          if ((b & ndtp_pkg::VER_MASK) != ndtp_pkg::VER_MAJOR) begin
            kind = RK_ERR;
            code = ndtp_pkg::ST_TLV_ERR;
          end else begin
            skip_left = ndtp_pkg::CC_SKIP;
            parse_ph  = ndtp_pkg::PH_SKIP_CC;
          end
        end
        ndtp_pkg::PH_SKIP_CC: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) parse_ph = ndtp_pkg::PH_CONTENT;
        end
        ndtp_pkg::PH_CONTENT: begin
          if (b != ndtp_pkg::TLV_NDEF) begin
            kind = RK_ERR;
            code = ndtp_pkg::ST_NO_DATA;
          end else begin
            parse_ph = ndtp_pkg::PH_SKIP_LEN;
          end
        end
        ndtp_pkg::PH_SKIP_LEN: parse_ph = ndtp_pkg::PH_HEADER;
        ndtp_pkg::PH_HEADER: begin
          sr_flag = b[ndtp_pkg::HDR_SR_BIT];
          il_flag = b[ndtp_pkg::HDR_IL_BIT];
          if (b[ndtp_pkg::TNF_W-1:0] != tnf_cfg) begin
            kind = RK_ERR;
            code = ndtp_pkg::ST_NDEF_ERR;
          end else begin
            parse_ph = ndtp_pkg::PH_TYPE_LEN;
          end
        end
        ndtp_pkg::PH_TYPE_LEN: begin
          type_len = b;
          pay_left = '0;
          len_cnt  = '0;
          parse_ph = ndtp_pkg::PH_PAY_LEN;
        end
        ndtp_pkg::PH_PAY_LEN: begin
          pay_left = {pay_left[ndtp_pkg::PAYLEN_W-ndtp_pkg::BYTE_W-1:0], b};
          if (sr_flag || len_cnt == ndtp_pkg::LEN_LAST) begin
            if (il_flag) begin
              parse_ph = ndtp_pkg::PH_ID_LEN;
            end else if (type_len != ndtp_pkg::ONE_TYPE_LEN) begin
              kind = RK_ERR;
              code = ndtp_pkg::ST_NDEF_ERR;
            end else begin
              parse_ph = ndtp_pkg::PH_TYPE;
            end
          end else begin
            len_cnt = len_cnt + 1'b1;
          end
        end
        ndtp_pkg::PH_ID_LEN: begin
          id_len = b;
          if (type_len != ndtp_pkg::ONE_TYPE_LEN) begin
            kind = RK_ERR;
            code = ndtp_pkg::ST_NDEF_ERR;
          end else begin
            parse_ph = ndtp_pkg::PH_TYPE;
          end
        end
        ndtp_pkg::PH_TYPE: begin
          if (b != type_cfg) begin
            kind = RK_ERR;
            code = ndtp_pkg::ST_NDEF_ERR;
          end else if (id_len != '0) begin
            skip_left = id_len;
            parse_ph  = ndtp_pkg::PH_SKIP_ID;
          end else begin
            parse_ph = ndtp_pkg::PH_LANG;
          end
        end
        ndtp_pkg::PH_SKIP_ID: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) parse_ph = ndtp_pkg::PH_LANG;
        end
        ndtp_pkg::PH_LANG: begin
          lang = b[ndtp_pkg::LANG_W-1:0];
          // flag a payload too short for status byte and language code
          if (pay_left == '0 || pay_left - 32'd1 < 32'(lang)) begin
            kind = RK_ERR;
            code = ndtp_pkg::ST_NDEF_ERR;
          end else begin
            pay_left = pay_left - 32'd1 - 32'(lang);
            if (lang != '0) begin
              skip_left = 8'(lang);
              parse_ph  = ndtp_pkg::PH_SKIP_LANG;
            end else begin
              kind = end_of_lang();
            end
          end
        end
        ndtp_pkg::PH_SKIP_LANG: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == '0) kind = end_of_lang();
        end
        ndtp_pkg::PH_TEXT: begin
          // drop a text byte that is the tag's last but not the record's last
          if (pay_left == 32'd1 || !it.last_byte) begin
            pay_left = pay_left - 32'd1;
            kind     = RK_TEXT;
            if (pay_left == '0) parse_ph = ndtp_pkg::PH_DONE;
          end
        end
        default: return;
      endcase
    end
    // tag ran out before the record was complete
    if (kind == RK_NONE && it.last_byte && parse_ph != ndtp_pkg::PH_DONE &&
        parse_ph != ndtp_pkg::PH_IDLE) begin
      kind = RK_ERR;
      code = ndtp_pkg::ST_NO_DATA;
    end
    if (kind == RK_NONE) return;
    if (kind == RK_ERR) parse_ph = ndtp_pkg::PH_DONE;
    r.text_byte  = (kind == RK_TEXT) ? b : '0;
    r.text_valid = (kind == RK_TEXT);
    r.last       = (kind == RK_TEXT) ? (pay_left == '0) : 1'b1;
    r.status     = (kind == RK_ERR) ? code : ndtp_pkg::ST_OK;
    pending_results.push_back(r);
  endfunction

  function automatic void compare_field(string name, logic [ndtp_pkg::BYTE_W-1:0] want,
                                        logic [ndtp_pkg::BYTE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Match one result against the oldest pending one
  function automatic void check_result(ndtp_pkg::result_t got);
    ndtp_pkg::result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected, actual byte %h valid %b last %b status %0d",
               $time, got.text_byte, got.text_valid, got.last, got.status);
      return;
    end
    want = pending_results.pop_front();
    compare_field("text_byte", want.text_byte, got.text_byte);
    compare_field("text_valid", want.text_valid, got.text_valid);
    compare_field("last", want.last, got.last);
    compare_field("status", want.status, got.status);
  endfunction

  // Track config writes, predict accepted items, check accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      parse_ph  = ndtp_pkg::PH_IDLE;
      skip_left = '0;
      pay_left  = '0;
      len_cnt   = '0;
      sr_flag   = 1'b0;
      il_flag   = 1'b0;
      type_len  = '0;
      id_len    = '0;
      tnf_cfg   = ndtp_pkg::TNF_RESET;
      type_cfg  = ndtp_pkg::TYPE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ndtp_pkg::CFG_IDX_TNF) tnf_cfg = cfg_data[ndtp_pkg::TNF_W-1:0];
        else if (cfg_index == ndtp_pkg::CFG_IDX_TYPE) type_cfg = cfg_data;
      end
      if (in_valid && in_ready)
        parse_tag_byte({in_data_byte, in_first_byte, in_last_byte});
      if (out_valid && out_ready)
        check_result({out_text_byte, out_text_valid, out_last, out_status});
    end
  end

  // Receiver: random stalls, one long hold on request
  initial begin
    int rx_hold;
    int r;
    rx_hold   = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold       = HOLD_CYCLES - 1;
        out_ready     <= 1'b0;
      end else if (!rx_stall_en) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_hold   = (r < 97) ? $urandom_range(3) : $urandom_range(40, 10);
        end
      end
    end
  end

  function automatic int tx_gap();
    int r;
    if (!tx_gap_en) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Offer one tag byte and hold it until accepted
  task automatic send_byte(input logic [ndtp_pkg::BYTE_W-1:0] d, input logic f,
                           input logic l, input bit counted);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_first_byte <= f;
    in_last_byte  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q, input bit starts, input int last_at,
                            input bit counted);
    for (int i = 0; i < q.size(); i++)
      send_byte(q[i], starts && (i == 0), i == last_at, counted);
  endtask

  // Stop offering and let every expected result come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [ndtp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ndtp_pkg::BYTE_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_format(input logic [ndtp_pkg::TNF_W-1:0] tnf,
                            input logic [ndtp_pkg::BYTE_W-1:0] rtype);
    wait_for_results();
    write_reg(ndtp_pkg::CFG_IDX_TNF, {5'($urandom), tnf});
    write_reg(ndtp_pkg::CFG_IDX_TYPE, rtype);
    write_reg(CFG_IDX_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    stim_tnf  = tnf;
    stim_type = rtype;
  endtask

  function automatic logic [ndtp_pkg::BYTE_W-1:0] hdr_byte(logic sr, logic il,
                                                           logic [ndtp_pkg::TNF_W-1:0] tnf,
                                                           logic [2:0] flags);
    return {flags, sr, il, tnf};
  endfunction

  // Random well-formed text record for the current format
  function automatic tag_msg_t random_good_msg();
    tag_msg_t m;
    logic     sr;
    logic     il;
    int       lang;
    sr         = ($urandom_range(99) < 70);
    il         = ($urandom_range(99) < 30);
    m.cc       = $urandom_range(1);
    m.ver      = ndtp_pkg::VER_MAJOR | 8'($urandom_range(15));
    m.tlv      = ndtp_pkg::TLV_NDEF;
    m.hdr      = hdr_byte(sr, il, stim_tnf, 3'($urandom_range(7)));
    if (!m.cc && m.hdr == ndtp_pkg::CC_MAGIC) m.cc = 1'b1;
    m.tlen     = ndtp_pkg::ONE_TYPE_LEN;
    m.id_len   = !il ? 8'd0 : ($urandom_range(99) < 3) ? 8'hFF : 8'($urandom_range(4));
    m.rtype    = stim_type;
    lang       = ($urandom_range(99) < 8) ? 63 : $urandom_range(5);
    m.text_len = ($urandom_range(99) < 80) ? $urandom_range(12) : $urandom_range(40, 13);
    m.stat     = {2'($urandom_range(3)), 6'(lang)};
    m.plen     = 32'(1 + lang + m.text_len);
    return m;
  endfunction

  // Lay out a tag image byte by byte
  function automatic byte_q_t build_tag(tag_msg_t m);
    byte_q_t q;
    if (m.cc) q = {ndtp_pkg::CC_MAGIC, m.ver, 8'($urandom), 8'($urandom), m.tlv,
                   8'($urandom)};
    q.push_back(m.hdr);
    q.push_back(m.tlen);
    if (m.hdr[ndtp_pkg::HDR_SR_BIT]) begin
      q.push_back(m.plen[7:0]);
    end else begin
      q.push_back(m.plen[31:24]);
      q.push_back(m.plen[23:16]);
      q.push_back(m.plen[15:8]);
      q.push_back(m.plen[7:0]);
    end
    if (m.hdr[ndtp_pkg::HDR_IL_BIT]) q.push_back(m.id_len);
    q.push_back(m.rtype);
    repeat (m.id_len) q.push_back(8'($urandom));
    q.push_back(m.stat);
    repeat (m.stat[ndtp_pkg::LANG_W-1:0]) q.push_back(8'($urandom));
    repeat (m.text_len) q.push_back(8'($urandom));
    return q;
  endfunction

  // One tag image: mostly well formed, some broken, cut short or noise
  task automatic send_random_tag();
    tag_msg_t m;
    byte_q_t  q;
    byte_q_t  noise;
    int       pick;
    int       last_at;
    int       keep;
    bit       quiet;
    quiet       = ($urandom_range(99) < 15);
    tx_gap_en   = !quiet;
    rx_stall_en = !quiet;
    m    = random_good_msg();
    pick = $urandom_range(99);
    if (pick < 50) begin
      // keep well formed
    end else if (pick < 55) begin
      m.cc  = 1'b1;
      m.ver = {ndtp_pkg::VER_MAJOR[7:4] ^ 4'($urandom_range(15, 1)), 4'($urandom)};
    end else if (pick < 60) begin
      m.cc  = 1'b1;
      m.tlv = ndtp_pkg::TLV_NDEF ^ 8'($urandom_range(255, 1));
    end else if (pick < 65) begin
      m.hdr[ndtp_pkg::TNF_W-1:0] = stim_tnf ^ 3'($urandom_range(7, 1));
      if (!m.cc && m.hdr == ndtp_pkg::CC_MAGIC) m.cc = 1'b1;
    end else if (pick < 70) begin
      m.tlen = ndtp_pkg::ONE_TYPE_LEN ^ 8'($urandom_range(255, 1));
    end else if (pick < 75) begin
      m.rtype = stim_type ^ 8'($urandom_range(255, 1));
    end else if (pick < 82) begin
      m.plen = $urandom_range(m.stat[ndtp_pkg::LANG_W-1:0]);
      if (m.hdr[ndtp_pkg::HDR_SR_BIT] == 1'b0) m.plen = m.plen & 32'hFF;
    end else if (pick < 88) begin
      // long record length: the tag ends before the text does
      m.hdr[ndtp_pkg::HDR_SR_BIT] = 1'b0;
      m.plen                      = $urandom;
      if (!m.cc && m.hdr == ndtp_pkg::CC_MAGIC) m.cc = 1'b1;
    end
    if (pick >= 94) begin
      repeat ($urandom_range(8, 1)) q.push_back(8'($urandom));
    end else begin
      q = build_tag(m);
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      last_at = q.size() - 1;
    end else if (pick < 55) begin
      last_at = $urandom_range(q.size() - 1);
      while (q.size() > last_at + 1) void'(q.pop_back());
    end else if (pick < 70) begin
      last_at = -1;
      if (q.size() > 1) begin
        keep = $urandom_range(q.size() - 1, 1);
        while (q.size() > keep) void'(q.pop_back());
      end
    end else begin
      last_at = -1;
    end
    send_bytes(q, 1'b1, last_at, 1'b1);
    // after the tag's last byte the parser is finished and ignores the rest
    if (last_at >= 0 && $urandom_range(99) < 25) begin
      repeat ($urandom_range(3, 1)) noise.push_back(8'($urandom));
      send_bytes(noise, 1'b0, $urandom_range(noise.size()), 1'b0);
    end
  endtask

  // Bytes without a first marker before any tag start are ignored
  task automatic test_idle_bytes();
    byte_q_t q;
    q = {8'hFF, 8'h00};
    send_bytes(q, 1'b0, 0, 1'b0);
    wait_for_results();
  endtask

  // Bad version, wrong TLV type, and a tag that ends on its magic byte
  task automatic test_cc_errors();
    byte_q_t q;
    q = {ndtp_pkg::CC_MAGIC, 8'h3F};
    send_bytes(q, 1'b1, -1, 1'b1);
    q = {ndtp_pkg::CC_MAGIC, ndtp_pkg::VER_MAJOR | 8'h0F, 8'hFF, 8'h00, 8'h02};
    send_bytes(q, 1'b1, -1, 1'b1);
    q = {ndtp_pkg::CC_MAGIC};
    send_bytes(q, 1'b1, 0, 1'b1);
    wait_for_results();
  endtask

  // Wrong TNF, wrong type length, wrong type byte
  task automatic test_header_errors();
    byte_q_t q;
    q = {hdr_byte(1'b1, 1'b0, ndtp_pkg::TNF_RESET ^ 3'd3, 3'd0)};
    send_bytes(q, 1'b1, -1, 1'b1);
    q = {hdr_byte(1'b1, 1'b0, ndtp_pkg::TNF_RESET, 3'd7), 8'h02, 8'h05};
    send_bytes(q, 1'b1, -1, 1'b1);
    q = {hdr_byte(1'b1, 1'b0, ndtp_pkg::TNF_RESET, 3'd0), ndtp_pkg::ONE_TYPE_LEN, 8'h05,
         8'h41};
    send_bytes(q, 1'b1, -1, 1'b1);
    wait_for_results();
  endtask

  // Zero payload length underflows; a status-byte-only payload is empty text
  task automatic test_empty_and_underflow();
    byte_q_t q;
    q = {hdr_byte(1'b1, 1'b0, ndtp_pkg::TNF_RESET, 3'd0), ndtp_pkg::ONE_TYPE_LEN, 8'h00,
         ndtp_pkg::TYPE_RESET, 8'h00};
    send_bytes(q, 1'b1, -1, 1'b1);
    q = {hdr_byte(1'b1, 1'b0, ndtp_pkg::TNF_RESET, 3'd0), ndtp_pkg::ONE_TYPE_LEN, 8'h01,
         ndtp_pkg::TYPE_RESET, 8'hC0};
    send_bytes(q, 1'b1, -1, 1'b1);
    wait_for_results();
  endtask

  // Tag ends inside the text: the last byte is dropped for a no-data status
  task automatic test_running_out();
    byte_q_t q;
    q = {hdr_byte(1'b1, 1'b0, ndtp_pkg::TNF_RESET, 3'd0), ndtp_pkg::ONE_TYPE_LEN, 8'h04,
         ndtp_pkg::TYPE_RESET, 8'h00, 8'hFF, 8'h00};
    send_bytes(q, 1'b1, 6, 1'b1);
    wait_for_results();
  endtask

  // Hold the receiver off while bytes keep coming so the input stalls
  task automatic test_backpressure();
    tag_msg_t m;
    byte_q_t  q;
    tx_gap_en     = 1'b0;
    rx_stall_en   = 1'b0;
    long_hold_req = 1'b1;
    repeat (4) begin
      m          = random_good_msg();
      m.id_len   = m.hdr[ndtp_pkg::HDR_IL_BIT] ? 8'd2 : 8'd0;
      m.text_len = 6;
      m.plen     = 32'(1 + m.stat[ndtp_pkg::LANG_W-1:0] + m.text_len);
      q          = build_tag(m);
      send_bytes(q, 1'b1, q.size() - 1, 1'b1);
    end
    wait_for_results();
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  task automatic run_tag_traffic(input int quota);
    int stop_at;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) send_random_tag();
  endtask

  // Random tags under several accepted formats, extremes included
  task automatic test_random_tags();
    set_format(ndtp_pkg::TNF_RESET, ndtp_pkg::TYPE_RESET);
    run_tag_traffic(PHASE_QUOTA);
    set_format('0, '0);
    run_tag_traffic(PHASE_QUOTA);
    set_format('1, '1);
    run_tag_traffic(PHASE_QUOTA);
    set_format(3'($urandom), 8'($urandom));
    run_tag_traffic(PHASE_QUOTA);
    wait_for_results();
  endtask

  // Run limit, well above the slowest correct run
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_first_byte = 1'b0;
    in_last_byte  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_cc_errors();
    test_header_errors();
    test_empty_and_underflow();
    test_running_out();
    test_backpressure();
    test_random_tags();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
